// ----- sv/teaa_pkg.sv -----
package teaa_pkg;

  localparam int OFFSET_BITS = 33;
  localparam int SEGMENT_COUNT_BITS = 16;
  localparam int CFG_BITS = 33;
  localparam int REQ_BITS = 32;
  localparam int MODE_BITS = 2;
  localparam int STATUS_BITS = 2;
  localparam int OUT_OFFSET_BITS = 33;
  localparam int OUT_COUNT_BITS = 16;

  // Compares run two bits wider than any operand so sums never wrap.
  localparam int CMP_BITS = ((OFFSET_BITS > CFG_BITS) ? OFFSET_BITS : CFG_BITS) + 2;

  localparam int PDATA_BITS = 64;
  localparam int PADDR_BITS = 5;
  localparam int REG_INDEX_BITS = 2;
  localparam int REG_ADDR_SHIFT = 3;

  localparam logic [REG_INDEX_BITS-1:0] REG_SEGMENT_BYTES = 2'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_LOW_WATER_BYTES = 2'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_EXTRA_SEGMENTS = 2'd2;

  localparam logic [CFG_BITS-1:0] SEGMENT_BYTES_RESET = CFG_BITS'(6 * 1024 * 1024);
  localparam logic [CFG_BITS-1:0] LOW_WATER_BYTES_RESET = CFG_BITS'((6 * 1024 * 1024) / 40);
  localparam logic EXTRA_SEGMENTS_RESET = 1'b1;

  localparam logic [CMP_BITS-1:0] ROUND_MASK = CMP_BITS'(7);

  localparam logic [MODE_BITS-1:0] MODE_FIXED = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_FREEABLE = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_RECLAIM = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_NEW_SEGMENT = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_TEMP = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_PERM = 2'd3;

  typedef struct packed {
    logic [OFFSET_BITS-1:0]        low_offset;
    logic [OFFSET_BITS-1:0]        high_offset;
    logic [SEGMENT_COUNT_BITS-1:0] segment_count;
    logic                          low_flag;
  } arena_state_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] segment_bytes;
    logic [CFG_BITS-1:0] low_water_bytes;
    logic                extra_segments_allowed;
  } arena_cfg_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]     status;
    logic [OUT_OFFSET_BITS-1:0] block_offset;
    logic [OUT_COUNT_BITS-1:0]  segment_number;
    logic                       low_memory;
    logic                       disable_sampling;
  } arena_result_t;

endpackage

// ----- sv/teaa_step.sv -----
module teaa_step (
  input  teaa_pkg::arena_state_t              state,
  input  teaa_pkg::arena_cfg_t                cfg,
  input  logic [teaa_pkg::MODE_BITS-1:0]      mode,
  input  logic [teaa_pkg::REQ_BITS-1:0]       request_bytes,
  output teaa_pkg::arena_state_t              state_next,
  output teaa_pkg::arena_result_t             result
);
  import teaa_pkg::*;

  logic [CMP_BITS-1:0] size;
  logic [CMP_BITS-1:0] low_water;
  logic [CMP_BITS-1:0] low_cur;
  logic [CMP_BITS-1:0] high_cur;
  logic [CMP_BITS-1:0] seg_top;
  logic [CMP_BITS-1:0] fix_low;
  logic [CMP_BITS-1:0] fix_high;
  logic [CMP_BITS-1:0] fix_end;
  logic [CMP_BITS-1:0] fix_at;
  logic [CMP_BITS-1:0] free_top;
  logic                need_segment;
  logic [SEGMENT_COUNT_BITS-1:0] count_inc;
  logic [CMP_BITS-1:0] offset;

  always_comb begin
    size      = (CMP_BITS'(request_bytes) + ROUND_MASK) & ~ROUND_MASK;
    low_water = CMP_BITS'(cfg.low_water_bytes);
    low_cur   = CMP_BITS'(state.low_offset);
    high_cur  = CMP_BITS'(state.high_offset);
    seg_top   = CMP_BITS'(cfg.segment_bytes[OFFSET_BITS-1:0]);
    count_inc = state.segment_count + SEGMENT_COUNT_BITS'(1);

    // A fixed request first checks whether the top is below twice the low-water mark.
    need_segment = high_cur < (low_water << 1);
    fix_low  = need_segment ? '0 : low_cur;
    fix_high = need_segment ? seg_top : high_cur;
    fix_end  = fix_low + size;
    fix_at   = fix_high - size;
    free_top = low_cur + size;

    state_next = state;
    result.status = ST_DONE;
    result.disable_sampling = 1'b0;
    offset = '0;

    case (mode)
      MODE_FIXED: begin
        if (request_bytes == '0) begin
          result.status = ST_ZERO;
        end else if (need_segment && !cfg.extra_segments_allowed) begin
          result.status = ST_PERM;
          result.disable_sampling = 1'b1;
        end else begin
          if (need_segment) begin
            state_next.low_offset    = '0;
            state_next.high_offset   = fix_high[OFFSET_BITS-1:0];
            state_next.segment_count = count_inc;
          end
          if (fix_high <= fix_end) begin
            state_next.low_flag = 1'b1;
            result.status = ST_TEMP;
          end else begin
            if (fix_at < fix_low + low_water) begin
              state_next.low_flag = 1'b1;
            end
            state_next.high_offset = fix_at[OFFSET_BITS-1:0];
            offset = fix_at;
          end
        end
      end
      MODE_FREEABLE: begin
        if (free_top >= high_cur) begin
          state_next.low_flag = 1'b1;
          result.status = ST_TEMP;
        end else begin
          if (free_top + low_water > high_cur) begin
            state_next.low_flag = 1'b1;
          end
          offset = low_cur;
          state_next.low_offset = free_top[OFFSET_BITS-1:0];
        end
      end
      MODE_RECLAIM: begin
        state_next.low_offset = '0;
        state_next.low_flag   = 1'b0;
      end
      default: begin
        state_next.low_offset    = '0;
        state_next.high_offset   = seg_top[OFFSET_BITS-1:0];
        state_next.segment_count = count_inc;
      end
    endcase

    result.block_offset   = offset[OUT_OFFSET_BITS-1:0];
    result.segment_number = OUT_COUNT_BITS'(state_next.segment_count);
    result.low_memory     = state_next.low_flag;
  end

endmodule

// ----- sv/two_ended_arena_allocator.sv -----
// A request accepted into the input register passes through the combinational step
// into the output register when the output is free; the receiver takes it from there.
// Throughput: one request per cycle while out_stall is low; the offset update is a single
// add and compare pass, so the next request sees the new offsets at once.
// Reset (synchronous, active high) clears the offsets, segment count and low-memory
// flag, empties both registers and loads the configuration registers' reset values.
module two_ended_arena_allocator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [teaa_pkg::MODE_BITS-1:0]        mode,
  input  logic [teaa_pkg::REQ_BITS-1:0]         request_bytes,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [teaa_pkg::STATUS_BITS-1:0]      status,
  output logic [teaa_pkg::OUT_OFFSET_BITS-1:0]  block_offset,
  output logic [teaa_pkg::OUT_COUNT_BITS-1:0]   segment_number,
  output logic                                  low_memory,
  output logic                                  disable_sampling,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [teaa_pkg::PADDR_BITS-1:0]       paddr,
  input  logic [teaa_pkg::PDATA_BITS-1:0]       pwdata,
  output logic [teaa_pkg::PDATA_BITS-1:0]       prdata,
  output logic                                  pready
);
  import teaa_pkg::*;

  arena_state_t  state;
  arena_state_t  state_next;
  arena_cfg_t    cfg;
  arena_result_t result;
  arena_result_t result_next;

  logic                  item_valid;
  logic [MODE_BITS-1:0]  item_mode;
  logic [REQ_BITS-1:0]   item_req;
  logic                  out_free;
  logic                  item_fire;
  logic                  cfg_write;
  logic [REG_INDEX_BITS-1:0] reg_index;

  assign out_free  = !out_valid || !out_stall;
  assign item_fire = item_valid && out_free;
  assign in_stall  = item_valid && !out_free;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[REG_ADDR_SHIFT +: REG_INDEX_BITS];

  teaa_step u_step (
    .state         (state),
    .cfg           (cfg),
    .mode          (item_mode),
    .request_bytes (item_req),
    .state_next    (state_next),
    .result        (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_mode <= mode;
      item_req  <= request_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (item_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.segment_bytes          <= SEGMENT_BYTES_RESET;
      cfg.low_water_bytes        <= LOW_WATER_BYTES_RESET;
      cfg.extra_segments_allowed <= EXTRA_SEGMENTS_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        REG_SEGMENT_BYTES:   cfg.segment_bytes <= pwdata[CFG_BITS-1:0];
        REG_LOW_WATER_BYTES: cfg.low_water_bytes <= pwdata[CFG_BITS-1:0];
        REG_EXTRA_SEGMENTS:  cfg.extra_segments_allowed <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_SEGMENT_BYTES:   prdata = PDATA_BITS'(cfg.segment_bytes);
      REG_LOW_WATER_BYTES: prdata = PDATA_BITS'(cfg.low_water_bytes);
      REG_EXTRA_SEGMENTS:  prdata = PDATA_BITS'(cfg.extra_segments_allowed);
      default:             prdata = '0;
    endcase
  end

  assign status           = result.status;
  assign block_offset     = result.block_offset;
  assign segment_number   = result.segment_number;
  assign low_memory       = result.low_memory;
  assign disable_sampling = result.disable_sampling;

endmodule
